>>> rtl/utfv_pkg.sv
`default_nettype none
package utfv_pkg;

    localparam int unsigned QDepth = 4;
    localparam int unsigned QAw    = $clog2(QDepth);

    localparam logic [7:0] AsciiMax   = 8'h7f;
    localparam logic [7:0] Mask2      = 8'he0;
    localparam logic [7:0] Lead2      = 8'hc0;
    localparam logic [7:0] Mask3      = 8'hf0;
    localparam logic [7:0] Lead3      = 8'he0;
    localparam logic [7:0] Mask4      = 8'hf8;
    localparam logic [7:0] Lead4      = 8'hf0;
    localparam logic [7:0] ContMask   = 8'hc0;
    localparam logic [7:0] ContPat    = 8'h80;
    localparam logic [7:0] EdLead     = 8'hed;
    localparam logic [7:0] SurrMask   = 8'ha0;
    localparam logic [7:0] RepairByte = 8'h80;

    // one to two results produced by one accepted byte; last/valid belong
    // to the final result of the group
    typedef struct packed {
        logic       two;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       last;
        logic       valid;
    } t_group;

    // queue read side, seen by the back end
    typedef struct packed {
        logic   empty;
        t_group data;
    } t_q_rd;

endpackage
`default_nettype wire

>>> rtl/utfv_front.sv
`default_nettype none
module utfv_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_accept,
    input  wire [7:0]            i_in_byte,
    input  wire                  i_in_last,
    output logic                 o_q_push,
    output utfv_pkg::t_group     o_q_data
);

    logic [1:0] r_pend, n_pend;
    logic       r_held, n_held;
    logic       r_err,  n_err;

    logic       first_en;
    logic [7:0] first_byte;
    logic       second_en;
    logic [7:0] second_byte;
    logic [1:0] pend_a;
    logic       err_a;

    always_comb begin
        first_en    = r_held;
        first_byte  = utfv_pkg::EdLead;
        pend_a      = r_pend;
        err_a       = r_err;
        second_en   = 1'b1;
        second_byte = i_in_byte;
        n_held      = 1'b0;

        // held ED resolved by the byte that follows it
        if (r_held) begin
            if ((i_in_byte & utfv_pkg::SurrMask) == utfv_pkg::SurrMask) begin
                err_a      = 1'b1;
                pend_a     = 2'd0;
                first_byte = utfv_pkg::RepairByte;
            end else begin
                pend_a = 2'd2;
            end
        end

        n_pend = pend_a;
        n_err  = err_a;

        if (pend_a != 2'd0) begin
            n_pend = pend_a - 2'd1;
            if ((i_in_byte & utfv_pkg::ContMask) != utfv_pkg::ContPat) begin
                n_err       = 1'b1;
                second_byte = utfv_pkg::RepairByte;
            end
        end else if (i_in_byte == utfv_pkg::EdLead && !i_in_last) begin
            n_held    = 1'b1;
            second_en = 1'b0;
        end else if (i_in_byte <= utfv_pkg::AsciiMax) begin
            n_pend = 2'd0;
        end else if ((i_in_byte & utfv_pkg::Mask2) == utfv_pkg::Lead2) begin
            n_pend = 2'd1;
        end else if ((i_in_byte & utfv_pkg::Mask3) == utfv_pkg::Lead3) begin
            n_pend = 2'd2;
        end else if ((i_in_byte & utfv_pkg::Mask4) == utfv_pkg::Lead4) begin
            n_pend = 2'd3;
        end else begin
            n_pend      = 2'd0;
            n_err       = 1'b1;
            second_byte = utfv_pkg::RepairByte;
        end

        o_q_data.two   = first_en && second_en;
        o_q_data.byte0 = first_en ? first_byte : second_byte;
        o_q_data.byte1 = second_byte;
        o_q_data.last  = i_in_last;
        o_q_data.valid = i_in_last && !n_err && (n_pend == 2'd0);
        o_q_push       = i_accept && (first_en || second_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'd0;
            r_held <= 1'b0;
            r_err  <= 1'b0;
        end else if (i_accept) begin
            if (i_in_last) begin
                r_pend <= 2'd0;
                r_held <= 1'b0;
                r_err  <= 1'b0;
            end else begin
                r_pend <= n_pend;
                r_held <= n_held;
                r_err  <= n_err;
            end
        end
    end

    // an ED is only held from the idle lead position
    a_held_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held |-> (r_pend == 2'd0))
        else $error("ED held with continuations pending");

    // a final byte always yields a result
    a_last_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_in_last) |-> o_q_push)
        else $error("final byte produced no result");

    // message boundary clears all state
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_in_last) |=> (r_pend == 2'd0 && !r_held && !r_err))
        else $error("state survived end of message");

endmodule
`default_nettype wire

>>> rtl/utfv_queue.sv
`default_nettype none
module utfv_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  wire utfv_pkg::t_group i_data,
    input  wire                  i_pop,
    output logic                 o_full,
    output utfv_pkg::t_q_rd      o_rd
);

    utfv_pkg::t_group r_mem [utfv_pkg::QDepth];

    logic [utfv_pkg::QAw:0] r_wr, r_rd, r_cnt;
    logic                   do_pop;

    assign o_full       = (r_cnt == (utfv_pkg::QAw+1)'(utfv_pkg::QDepth));
    assign o_rd.empty   = (r_cnt == '0);
    assign o_rd.data    = r_mem[r_rd[utfv_pkg::QAw-1:0]];
    assign do_pop       = i_pop && !o_rd.empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr[utfv_pkg::QAw-1:0]] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && do_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue written while full");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (utfv_pkg::QAw+1)'(utfv_pkg::QDepth))
        else $error("queue count out of range");

    a_cnt_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == (r_wr - r_rd))
        else $error("queue count disagrees with pointers");

endmodule
`default_nettype wire

>>> rtl/utfv_back.sv
`default_nettype none
module utfv_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire utfv_pkg::t_q_rd i_rd,
    output logic                 o_q_pop,
    input  wire                  i_pop,
    output logic                 o_empty,
    output logic [7:0]           o_out_byte,
    output logic                 o_out_last,
    output logic                 o_msg_valid
);

    utfv_pkg::t_group r_grp;
    logic             r_vld;
    logic             r_sel;
    logic             final_res;
    logic             take;

    assign final_res   = !r_grp.two || r_sel;
    assign o_empty     = !r_vld;
    assign o_out_byte  = r_sel ? r_grp.byte1 : r_grp.byte0;
    assign o_out_last  = final_res && r_grp.last;
    assign o_msg_valid = final_res && r_grp.last && r_grp.valid;

    // load a new group once the current one is fully delivered
    assign take    = !r_vld || (i_pop && final_res);
    assign o_q_pop = take && !i_rd.empty;

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_grp <= i_rd.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_sel <= 1'b0;
        end else if (take) begin
            r_vld <= !i_rd.empty;
            r_sel <= 1'b0;
        end else if (i_pop) begin
            r_sel <= 1'b1;
        end
    end

    a_sel_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && r_sel) |-> r_grp.two)
        else $error("second slot shown for single group");

    a_valid_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_msg_valid |-> o_out_last)
        else $error("verdict outside final result");

    a_sel_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && !r_sel && r_grp.two && i_pop) |=> (r_vld && r_sel))
        else $error("second result of group skipped");

endmodule
`default_nettype wire

>>> rtl/utf8_validate_and_repair.sv
// Channel   Direction  Handshake (accept when)     Payload
// input     in         i_push  && !o_full          i_in_byte, i_in_last
// result    out        i_pop   && !o_empty         o_out_byte, o_out_last, o_msg_valid
//
// One byte accepted per cycle while o_full is low; each byte yields zero, one or two
// results, which are queued and then registered in the back end. With i_pop high the
// output delivers one a cycle, so surrogate-resolving ED pairs drain at one per cycle.
// Reset is synchronous, active low, and clears the lead state and the queue.
// o_full rises when the four-group queue between front and back fills.
`default_nettype none
module utf8_validate_and_repair (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_push,
    output logic       o_full,
    input  wire [7:0]  i_in_byte,
    input  wire        i_in_last,
    input  wire        i_pop,
    output logic       o_empty,
    output logic [7:0] o_out_byte,
    output logic       o_out_last,
    output logic       o_msg_valid
);

    logic              accept;
    logic              q_push;
    logic              q_pop;
    utfv_pkg::t_group  q_wdata;
    utfv_pkg::t_q_rd   q_rd;

    assign accept = i_push && !o_full;

    utfv_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_in_byte (i_in_byte),
        .i_in_last (i_in_last),
        .o_q_push  (q_push),
        .o_q_data  (q_wdata)
    );

    utfv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_full  (o_full),
        .o_rd    (q_rd)
    );

    utfv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd        (q_rd),
        .o_q_pop     (q_pop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last),
        .o_msg_valid (o_msg_valid)
    );

endmodule
`default_nettype wire
